// ----- rtl/sccp_pkg.sv -----
// ----------------------------------------------------------------------------
// sccp_pkg
// Shared types and constants of the sector cache clock-policy controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sccp_pkg;

    // slot count of the cache
    localparam int NUM_ENTRIES_DEF = 64;

    // fixed field widths
    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;
    localparam int OP_W     = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ZERO  = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

    // classified command as it sits in the queue
    typedef struct packed {
        logic                flush;
        logic                writes;
        logic [SECTOR_W-1:0] sector;
    } sccp_cmd_t;

    // queue handshake from front to back
    typedef struct packed {
        logic      valid;
        sccp_cmd_t cmd;
    } sccp_queue_t;

endpackage

`default_nettype wire

// ----- rtl/sccp_ram.sv -----
// ----------------------------------------------------------------------------
// sccp_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- rtl/sccp_front.sv -----
// ----------------------------------------------------------------------------
// sccp_front
// Accepts commands, decodes the op and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_front
    import sccp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [SECTOR_W-1:0] sector,
    output logic                     busy,
    input  wire logic                pop,
    output sccp_queue_t              cmd_q
);

    sccp_cmd_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    sccp_cmd_t  cmd;

    // decode the op
    always_comb
    begin
        cmd.flush  = (op == OP_FLUSH);
        cmd.writes = (op == OP_WRITE) || (op == OP_ZERO);
        cmd.sector = sector;
    end

    assign busy        = (count_reg == 2'd2);
    assign push        = start && !busy;
    assign cmd_q.valid = (count_reg != 2'd0);
    assign cmd_q.cmd   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sccp_back.sv -----
// ----------------------------------------------------------------------------
// sccp_back
// Executes queued commands: tag scan, clock sweep, fill and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_back
    import sccp_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sccp_queue_t         cmd_q,
    output logic                     pop,
    output logic                     done,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot,
    output logic                     fill,
    output logic                     writeback,
    output logic [SECTOR_W-1:0]      writeback_sector,
    output logic                     writeback_was_dirty,
    output logic                     last
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_MISS   = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_VICT   = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;
    localparam logic [2:0] S_FLEMIT = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [NUM_ENTRIES-1:0] acc_reg, acc_next;
    logic [NUM_ENTRIES-1:0] dirty_reg, dirty_next;
    logic [IW-1:0]          hand_reg, hand_next;
    logic [IW-1:0]          idx_reg, idx_next;
    sccp_cmd_t              cmd_reg, cmd_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg, hit_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   fill_reg, fill_next;
    logic                   wb_reg, wb_next;
    logic [SECTOR_W-1:0]    wb_sector_reg, wb_sector_next;
    logic                   wb_dirty_reg, wb_dirty_next;
    logic                   last_reg, last_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_addr;
    logic [SECTOR_W-1:0]    ram_rdata;
    logic [NUM_ENTRIES-1:0] vd;
    logic [NUM_ENTRIES-1:0] vd_above;
    logic [IW-1:0]          idx_inc;
    logic [IW-1:0]          hand_inc;

    sccp_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (NUM_ENTRIES)
    ) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd_reg.sector),
        .rdata (ram_rdata)
    );

    assign vd       = valid_reg & dirty_reg;
    assign vd_above = (vd >> idx_reg) >> 1;
    assign idx_inc  = idx_reg + IW'(1);
    assign hand_inc = (hand_reg == IDX_LAST) ? '0 : hand_reg + IW'(1);

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        acc_next       = acc_reg;
        dirty_next     = dirty_reg;
        hand_next      = hand_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = idx_reg;
        out_valid_next = 1'b0;
        hit_next       = 1'b0;
        slot_next      = slot_reg;
        fill_next      = 1'b0;
        wb_next        = 1'b0;
        wb_sector_next = '0;
        wb_dirty_next  = 1'b0;
        last_next      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_q.valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = cmd_q.cmd;
                    idx_next   = '0;
                    state_next = cmd_q.cmd.flush ? S_FLUSH : S_LOOK;
                end
            end

            // skip free slots, read the tag of a valid one
            S_LOOK:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = S_CMP;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_CMP:
            begin
                if (ram_rdata == cmd_reg.sector)
                begin
                    acc_next[idx_reg] = 1'b1;
                    if (cmd_reg.writes)
                    begin
                        dirty_next[idx_reg] = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    hit_next       = 1'b1;
                    slot_next      = SLOT_W'(idx_reg);
                    state_next     = S_IDLE;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_LOOK;
                end
            end

            // free slot under the hand is taken directly
            S_MISS:
            begin
                if (!valid_reg[hand_reg])
                begin
                    ram_we               = 1'b1;
                    ram_addr             = hand_reg;
                    valid_next[hand_reg] = 1'b1;
                    acc_next[hand_reg]   = 1'b1;
                    dirty_next[hand_reg] = cmd_reg.writes;
                    hand_next            = hand_inc;
                    out_valid_next       = 1'b1;
                    fill_next            = 1'b1;
                    slot_next            = SLOT_W'(hand_reg);
                    state_next           = S_IDLE;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end

            // clear accessed bits until an unaccessed slot is found
            S_SWEEP:
            begin
                ram_addr = hand_reg;
                if (acc_reg[hand_reg])
                begin
                    acc_next[hand_reg] = 1'b0;
                    hand_next          = hand_inc;
                end
                else if (valid_reg[hand_reg])
                begin
                    state_next = S_VICT;
                end
                else
                begin
                    ram_we               = 1'b1;
                    valid_next[hand_reg] = 1'b1;
                    acc_next[hand_reg]   = 1'b1;
                    dirty_next[hand_reg] = cmd_reg.writes;
                    out_valid_next       = 1'b1;
                    fill_next            = 1'b1;
                    slot_next            = SLOT_W'(hand_reg);
                    state_next           = S_IDLE;
                end
            end

            // victim tag is in ram_rdata; replace it
            S_VICT:
            begin
                ram_we               = 1'b1;
                ram_addr             = hand_reg;
                valid_next[hand_reg] = 1'b1;
                acc_next[hand_reg]   = 1'b1;
                dirty_next[hand_reg] = cmd_reg.writes;
                out_valid_next       = 1'b1;
                fill_next            = 1'b1;
                wb_next              = 1'b1;
                wb_sector_next       = ram_rdata;
                wb_dirty_next        = dirty_reg[hand_reg];
                slot_next            = SLOT_W'(hand_reg);
                state_next           = S_IDLE;
            end

            S_FLUSH:
            begin
                if (vd[idx_reg])
                begin
                    state_next = S_FLEMIT;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_FLEMIT:
            begin
                dirty_next[idx_reg] = 1'b0;
                out_valid_next      = 1'b1;
                wb_next             = 1'b1;
                wb_sector_next      = ram_rdata;
                wb_dirty_next       = 1'b1;
                slot_next           = SLOT_W'(idx_reg);
                last_next           = ~|vd_above;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FLUSH;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            acc_reg       <= '0;
            dirty_reg     <= '0;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            acc_reg       <= acc_next;
            dirty_reg     <= dirty_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        fill_reg      <= fill_next;
        wb_reg        <= wb_next;
        wb_sector_reg <= wb_sector_next;
        wb_dirty_reg  <= wb_dirty_next;
        last_reg      <= last_next;
    end

    assign done                = out_valid_reg;
    assign hit                 = hit_reg;
    assign slot                = slot_reg;
    assign fill                = fill_reg;
    assign writeback           = wb_reg;
    assign writeback_sector    = wb_sector_reg;
    assign writeback_was_dirty = wb_dirty_reg;
    assign last                = last_reg;

    // a hit never fills or writes back
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> !fill_reg && !wb_reg)
        else $error("hit beat carries fill or writeback");

    // a beat with neither hit nor fill is a flush write-back of a dirty slot
    a_flush_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg && !fill_reg |-> wb_reg && wb_dirty_reg)
        else $error("flush beat malformed");

    // a fill leaves the filled slot valid
    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_next && fill_next |=> valid_reg[$past(ram_addr)])
        else $error("filled slot not valid");

    // only one beat per access; access beats are always last
    a_access_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (hit_reg || fill_reg) |-> last_reg)
        else $error("access beat not last");

endmodule

`default_nettype wire

// ----- rtl/sector_cache_clock_policy.sv -----
// A hit is found by the tag scan, which spends a look state (RAM read) and a compare
// state on each valid slot and a look state alone on each free slot. A miss fills a
// free slot under the hand directly, else sweeps the hand and reads the victim tag
// before replacing it. A flush scans every slot and emits a beat per dirty one.
// One command in the engine, two more queued (busy when full); after an access the next
// is taken while its beat is out. Results cannot stall. Reset clears all bits and hand.
// ----------------------------------------------------------------------------
// sector_cache_clock_policy
// Tag and clock-replacement controller of a fully associative sector cache.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_clock_policy
    import sccp_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [SECTOR_W-1:0] sector,
    output logic                     busy,
    output logic                     done,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot,
    output logic                     fill,
    output logic                     writeback,
    output logic [SECTOR_W-1:0]      writeback_sector,
    output logic                     writeback_was_dirty,
    output logic                     last
);

    sccp_queue_t q;
    logic        pop;

    sccp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .sector (sector),
        .busy   (busy),
        .pop    (pop),
        .cmd_q  (q)
    );

    sccp_back #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd_q               (q),
        .pop                 (pop),
        .done                (done),
        .hit                 (hit),
        .slot                (slot),
        .fill                (fill),
        .writeback           (writeback),
        .writeback_sector    (writeback_sector),
        .writeback_was_dirty (writeback_was_dirty),
        .last                (last)
    );

endmodule

`default_nettype wire

// ----- tb/sccp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sccp_checker
// Watches the command and result channels of the sector cache controller,
// keeps its own tag/clock-policy state, predicts every result beat and
// compares each strobed beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_checker
    import sccp_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [SECTOR_W-1:0] sector,
    input  wire logic                done,
    input  wire logic                hit,
    input  wire logic [SLOT_W-1:0]   slot,
    input  wire logic                fill,
    input  wire logic                writeback,
    input  wire logic [SECTOR_W-1:0] writeback_sector,
    input  wire logic                writeback_was_dirty,
    input  wire logic                last,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                fill;
        logic                writeback;
        logic [SECTOR_W-1:0] wb_sector;
        logic                wb_dirty;
        logic                last;
    } beat_t;

    // shadow cache state
    logic [SECTOR_W-1:0] tag_q [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] vld_q, acc_q, dty_q;
    int unsigned hand_q;
    beat_t expected_beats[$];

    assign pending = expected_beats.size();

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic beat_t mk(logic h, int unsigned s, logic f, logic w,
                                 logic [SECTOR_W-1:0] ws, logic wd, logic l);
        beat_t b;
        b.hit = h; b.slot = s[SLOT_W-1:0]; b.fill = f; b.writeback = w;
        b.wb_sector = ws; b.wb_dirty = wd; b.last = l;
        return b;
    endfunction

    function automatic void step_hand();
        hand_q = (hand_q + 1 >= NUM_ENTRIES) ? 0 : hand_q + 1;
    endfunction

    // apply one accepted command to the shadow state, queue its beats
    task automatic predict_access(input logic [OP_W-1:0] c, input logic [SECTOR_W-1:0] s);
        logic wr;
        int unsigned dest;
        int n;
        int guard;
        beat_t b;
        wr = (c == OP_WRITE) || (c == OP_ZERO);
        if (c == OP_FLUSH)
        begin
            n = 0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (vld_q[i] && dty_q[i])
                begin
                    expected_beats.push_back(mk(1'b0, i, 1'b0, 1'b1, tag_q[i], 1'b1, 1'b0));
                    dty_q[i] = 1'b0;
                    n++;
                end
            end
            if (n > 0)
            begin
                b = expected_beats.pop_back();
                b.last = 1'b1;
                expected_beats.push_back(b);
            end
            return;
        end
        // lookup
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (vld_q[i] && tag_q[i] == s)
            begin
                acc_q[i] = 1'b1;
                if (wr) dty_q[i] = 1'b1;
                expected_beats.push_back(mk(1'b1, i, 1'b0, 1'b0, '0, 1'b0, 1'b1));
                return;
            end
        end
        // miss: free slot under the hand, else clock sweep
        b = mk(1'b0, 0, 1'b1, 1'b0, '0, 1'b0, 1'b1);
        if (!vld_q[hand_q])
        begin
            dest = hand_q;
            step_hand();
        end
        else
        begin
            guard = 0;
            while (acc_q[hand_q] && guard <= NUM_ENTRIES)
            begin
                acc_q[hand_q] = 1'b0;
                step_hand();
                guard++;
            end
            dest = hand_q;
            if (vld_q[dest])
            begin
                b.writeback = 1'b1;
                b.wb_sector = tag_q[dest];
                b.wb_dirty  = dty_q[dest];
            end
        end
        tag_q[dest] = s;
        vld_q[dest] = 1'b1;
        acc_q[dest] = 1'b1;
        dty_q[dest] = wr;
        b.slot = dest[SLOT_W-1:0];
        expected_beats.push_back(b);
    endtask

    // compare one result beat with the oldest prediction
    task automatic check_beat();
        beat_t e;
        if (expected_beats.size() == 0)
        begin
            report_mismatch("result beat with nothing expected");
            return;
        end
        e = expected_beats.pop_front();
        if (hit !== e.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", hit, e.hit));
        if (slot !== e.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", slot, e.slot));
        if (fill !== e.fill)
            report_mismatch($sformatf("fill %0b, expected %0b", fill, e.fill));
        if (writeback !== e.writeback)
            report_mismatch($sformatf("writeback %0b, expected %0b", writeback, e.writeback));
        if (writeback_sector !== e.wb_sector)
            report_mismatch($sformatf("writeback_sector %h, expected %h",
                                      writeback_sector, e.wb_sector));
        if (writeback_was_dirty !== e.wb_dirty)
            report_mismatch($sformatf("writeback_was_dirty %0b, expected %0b",
                                      writeback_was_dirty, e.wb_dirty));
        if (last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, e.last));
    endtask

    initial
    begin
        errors = 0;
        vld_q  = '0;
        acc_q  = '0;
        dty_q  = '0;
        hand_q = 0;
    end

    // results are checked before the command of the same edge is predicted;
    // the block cannot answer a command on its accepting edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) check_beat();
            if (start && !busy) predict_access(op, sector);
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_sector_cache_clock_policy.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sector_cache_clock_policy
// Drives directed and random access/flush commands into the sector cache
// controller with random gaps; a checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sector_cache_clock_policy;
    import sccp_pkg::*;

    localparam int N_RANDOM = 200;
    localparam int DRAIN_CYCLES = 400;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector;
    logic                busy;
    logic                done;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fill;
    logic                writeback;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                writeback_was_dirty;
    logic                last;
    int                  errors;
    int                  pending;

    sector_cache_clock_policy dut (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op), .sector(sector),
        .busy(busy), .done(done), .hit(hit), .slot(slot), .fill(fill),
        .writeback(writeback), .writeback_sector(writeback_sector),
        .writeback_was_dirty(writeback_was_dirty), .last(last)
    );

    sccp_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .sector(sector),
        .done(done), .hit(hit), .slot(slot), .fill(fill),
        .writeback(writeback), .writeback_sector(writeback_sector),
        .writeback_was_dirty(writeback_was_dirty), .last(last),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    // sector pool: a small working set (hits, sweeps) over a wide base
    logic [SECTOR_W-1:0] pool [96];

    // issue one command beat, with a random gap before it; start stays
    // high after the accepting edge until the next gap or drain
    task automatic send_cmd(input logic [OP_W-1:0] c, input logic [SECTOR_W-1:0] s);
        int gap;
        gap = $urandom_range(3);
        if ($urandom_range(3) == 0) gap = 0;
        if (gap > 0)
        begin
            start  <= 1'b0;
            op     <= OP_W'($urandom);
            sector <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        op     <= c;
        sector <= s;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // stop sending and wait until every predicted beat has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int k;
        int pick;
        logic [OP_W-1:0] c;
        rst_n  = 1'b0;
        start  = 1'b0;
        op     = OP_READ;
        sector = '0;
        for (int i = 0; i < 96; i++)
            pool[i] = (i < 4) ? {i[1] ? 16'hFFFF : 16'h0, i[0] ? 16'hFFFF : 16'h0}
                              : $urandom;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: flush when empty, extremes, each op, hits, then a flush
        send_cmd(OP_FLUSH, 32'h0);
        send_cmd(OP_READ,  32'h0000_0000);
        send_cmd(OP_WRITE, 32'hFFFF_FFFF);
        send_cmd(OP_ZERO,  32'hAAAA_5555);
        send_cmd(OP_READ,  32'hFFFF_FFFF);
        send_cmd(OP_WRITE, 32'h0000_0000);
        send_cmd(OP_ZERO,  32'h5555_AAAA);
        send_cmd(OP_FLUSH, 32'hFFFF_FFFF);
        send_cmd(OP_FLUSH, 32'h0);
        // pause until everything has come back
        wait_drained();
        // fill all slots and overflow to start the clock sweep
        for (int i = 0; i < 70; i++)
            send_cmd((i % 3 == 0) ? OP_WRITE : OP_READ, 32'h1000_0000 + i);
        send_cmd(OP_READ, 32'h1000_0045);
        send_cmd(OP_FLUSH, 32'h0);

        // random: mostly accesses over a working set larger than the cache
        for (k = 0; k < N_RANDOM; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 6)       c = OP_FLUSH;
            else if (pick < 50) c = OP_READ;
            else if (pick < 80) c = OP_WRITE;
            else                c = OP_ZERO;
            if ($urandom_range(9) == 0)
                send_cmd(c, $urandom);
            else
                send_cmd(c, pool[$urandom_range(95)]);
            if (k == N_RANDOM / 2) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
